@@ hw/rtl/gb5_pkg.sv @@
// Shared types, constants and tap table for the 5x5 Gaussian blur stream core.
`timescale 1ns / 1ps
`default_nettype none

package gb5_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int PIX_W     = 8;
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 12;
  localparam int COEF_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MIN_SIZE  = 5;

  localparam int WIN_DIM  = 5;
  localparam int WIN_TAPS = WIN_DIM * WIN_DIM;
  localparam int LS_ROWS  = WIN_DIM - 1;
  localparam int CENTER_TAP = WIN_TAPS / 2;

  localparam int NUM_COEF = 6;
  localparam int SUM_W    = PIX_W + 3;          // up to eight taps per class
  localparam int PROD_W   = SUM_W + COEF_W;
  localparam int PAIR_W   = PROD_W + 1;
  localparam int ACC_W    = PAIR_W + 3;
  localparam int FRAC_W   = 16;

  localparam int BMUL_W  = 16;
  localparam int BPROD_W = PIX_W + BMUL_W;
  localparam logic [BMUL_W-1:0] BORDER_MUL = 16'd50413;   // about 1/1.3 in Q0.16

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_COEF_D0      = 3'd2,
    CFG_COEF_D1      = 3'd3,
    CFG_COEF_D2      = 3'd4,
    CFG_COEF_D4      = 3'd5,
    CFG_COEF_D5      = 3'd6,
    CFG_COEF_D8      = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
  } out_item_t;

  typedef struct packed {
    logic primed;
    logic border;
    logic last;
  } pos_info_t;

  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
    logic ld_out;
  } stage_ld_t;

  typedef logic [LS_ROWS-1:0][PIX_W-1:0]   ls_word_t;
  typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_set_t;

  // Weight class of each window tap, row-major: squared distance 0,1,2,4,5,8 -> 0..5.
  localparam logic [2:0] TAP_CLASS [WIN_TAPS] = '{
    3'd5, 3'd4, 3'd3, 3'd4, 3'd5,
    3'd4, 3'd2, 3'd1, 3'd2, 3'd4,
    3'd3, 3'd1, 3'd0, 3'd1, 3'd3,
    3'd4, 3'd2, 3'd1, 3'd2, 3'd4,
    3'd5, 3'd4, 3'd3, 3'd4, 3'd5
  };

endpackage

`default_nettype wire

@@ hw/rtl/gaussian_blur_5x5_stream_core.sv @@
// Top level of the 5x5 Gaussian blur stream core: config registers and pipeline control.
// A result shows on out_valid after the item that completes it, which is the item 2*W+2
//   positions later in raster order, has passed through all six register stages.
// Throughput: one item per cycle with out_ready high; each stage stalls only on a full next.
// The line store is a one-port-write, one-port-read memory read at accept, written at ld2.
// Reset (synchronous, rst_n low) clears counters, stage valids and the line store fill count;
//   no clearing pass is needed, so items are taken from the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_blur_5x5_stream_core #(
  parameter int MAX_WIDTH = gb5_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire gb5_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output gb5_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [gb5_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gb5_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gb5_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int FW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (FW > WIDTH_W) ? FW : WIDTH_W;

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  coef_set_t           coef_r;

  logic [CW-1:0]       w_ext, w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  logic                accept;
  logic [AW-1:0]       col;
  pos_info_t           info;

  logic                s1_valid_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic [PIX_W-1:0]    s1_pix_r;
  logic [AW-1:0]       s1_col_r;
  pos_info_t           s1_info_r;
  logic                adv1, adv2, adv3, adv4, adv5, adv_out;
  stage_ld_t           ld;
  ls_word_t            ls;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_W'(1024);
      height_r <= HEIGHT_W'(1024);
      coef_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  width_r   <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_r  <= cfg_data[HEIGHT_W-1:0];
        CFG_COEF_D0:      coef_r[0] <= cfg_data[COEF_W-1:0];
        CFG_COEF_D1:      coef_r[1] <= cfg_data[COEF_W-1:0];
        CFG_COEF_D2:      coef_r[2] <= cfg_data[COEF_W-1:0];
        CFG_COEF_D4:      coef_r[3] <= cfg_data[COEF_W-1:0];
        CFG_COEF_D5:      coef_r[4] <= cfg_data[COEF_W-1:0];
        CFG_COEF_D8:      coef_r[5] <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size to what the line store and window support.
  always_comb begin
    w_ext = CW'(width_r);
    if (w_ext < CW'(MIN_SIZE)) begin
      w_eff = CW'(MIN_SIZE);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff = (height_r < HEIGHT_W'(MIN_SIZE)) ? HEIGHT_W'(MIN_SIZE) : height_r;
  end

  // A stage advances when it is empty or the one after it advances.
  always_comb begin
    adv_out   = !out_valid_r || out_ready;
    adv5      = !v5_r || adv_out;
    adv4      = !v4_r || adv5;
    adv3      = !v3_r || adv4;
    adv2      = !v2_r || adv3;
    adv1      = !s1_valid_r || adv2;
    in_ready  = adv1;
    accept    = in_valid && adv1;
    ld.ld2    = adv2 && s1_valid_r;
    ld.ld3    = adv3 && v2_r;
    ld.ld4    = adv4 && v3_r;
    ld.ld5    = adv5 && v4_r;
    ld.ld_out = adv_out && v5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1)    s1_valid_r  <= in_valid;
      if (adv2)    v2_r        <= s1_valid_r && s1_info_r.primed;
      if (adv3)    v3_r        <= v2_r;
      if (adv4)    v4_r        <= v3_r;
      if (adv5)    v5_r        <= v4_r;
      if (adv_out) out_valid_r <= v5_r;
    end
  end

  // Hold the accepted request beside the line store read.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_data.cmd ? '0 : in_data.pixel_in;
      s1_col_r  <= col;
      s1_info_r <= info;
    end
  end

  gb5_pos_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (accept),
    .w_eff (w_eff),
    .h_eff (h_eff),
    .col   (col),
    .info  (info)
  );

  gb5_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_lbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (col),
    .wr_en   (ld.ld2),
    .wr_addr (s1_col_r),
    .wr_data (ls_word_t'({s1_pix_r, ls[LS_ROWS-1:1]})),
    .rd_data (ls)
  );

  gb5_kernel u_kernel (
    .clk      (clk),
    .ld       (ld),
    .pix      (s1_pix_r),
    .ls       (ls),
    .border   (s1_info_r.border),
    .last     (s1_info_r.last),
    .coef     (coef_r),
    .out_data (out_data)
  );

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ hw/rtl/gb5_pos_ctrl.sv @@
// Input and output raster position counters, priming, border and frame-end decode.
`timescale 1ns / 1ps
`default_nettype none

module gb5_pos_ctrl #(
  parameter int MAX_WIDTH = gb5_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                step,
  input  wire logic [((($clog2(MAX_WIDTH+1)) > gb5_pkg::WIDTH_W) ?
                      ($clog2(MAX_WIDTH+1)) : gb5_pkg::WIDTH_W)-1:0] w_eff,
  input  wire logic [gb5_pkg::HEIGHT_W-1:0]        h_eff,
  output logic [$clog2(MAX_WIDTH)-1:0]             col,
  output gb5_pkg::pos_info_t                       info
);
  import gb5_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int FW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (FW > WIDTH_W) ? FW : WIDTH_W;

  logic [AW-1:0]       in_col_r, in_col_nxt;
  logic [1:0]          in_row_r, in_row_nxt;
  logic [AW-1:0]       out_col_r, out_col_nxt;
  logic [HEIGHT_W-1:0] out_row_r, out_row_nxt;

  logic [CW-1:0]       col_inc, oc_inc;
  logic                col_wrap, oc_wrap, orow_last;
  logic [AW-1:0]       oc;
  logic [HEIGHT_W-1:0] orow;
  logic [HEIGHT_W:0]   orow_inc;

  always_comb begin
    col      = (CW'(in_col_r) < w_eff) ? in_col_r : '0;
    col_inc  = CW'(col) + CW'(1);
    col_wrap = (col_inc >= w_eff);

    oc        = (CW'(out_col_r) < w_eff) ? out_col_r : '0;
    orow      = (out_row_r < h_eff) ? out_row_r : '0;
    oc_inc    = CW'(oc) + CW'(1);
    oc_wrap   = (oc_inc >= w_eff);
    orow_inc  = {1'b0, orow} + (HEIGHT_W+1)'(1);
    orow_last = (orow_inc >= {1'b0, h_eff});

    info.primed = (in_row_r == 2'd3) || ((in_row_r == 2'd2) && (col >= AW'(2)));
    info.border = (oc <= AW'(2)) || (orow <= HEIGHT_W'(2)) ||
                  (CW'(oc) >= (w_eff - CW'(2))) || (orow >= (h_eff - HEIGHT_W'(2)));
    info.last   = oc_wrap && orow_last;

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (step) begin
      if (col_wrap) begin
        in_col_nxt = '0;
        if (in_row_r != 2'd3) begin
          in_row_nxt = in_row_r + 2'd1;
        end
      end else begin
        in_col_nxt = col_inc[AW-1:0];
      end
      if (info.primed) begin
        if (info.last) begin
          // frame done: restart every counter
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (oc_wrap) begin
          out_col_nxt = '0;
          out_row_nxt = orow_inc[HEIGHT_W-1:0];
        end else begin
          out_col_nxt = oc_inc[AW-1:0];
          out_row_nxt = orow;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gb5_line_buf.sv @@
// Line store memory holding four earlier rows per column, with a fill count for reset.
`timescale 1ns / 1ps
`default_nettype none

module gb5_line_buf #(
  parameter int MAX_WIDTH = gb5_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  wire gb5_pkg::ls_word_t            wr_data,
  output gb5_pkg::ls_word_t                 rd_data
);
  import gb5_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int FW = $clog2(MAX_WIDTH + 1);

  ls_word_t      mem [MAX_WIDTH];
  ls_word_t      rd_data_r;
  ls_word_t      byp_data_r;
  logic          rd_ok_r;
  logic          rd_byp_r;
  logic [FW-1:0] fill_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r  <= mem[rd_addr];
      byp_data_r <= wr_data;
    end
  end

  // Columns are always written as a prefix from zero, so entries at or past the
  // fill count still read as zero, though the memory itself has no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      rd_ok_r  <= 1'b0;
      rd_byp_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_ok_r  <= (FW'(rd_addr) < fill_r);
        // forward a write to the same column in the same cycle
        rd_byp_r <= wr_en && (wr_addr == rd_addr);
      end
      if (wr_en && (FW'(wr_addr) == fill_r)) begin
        fill_r <= fill_r + FW'(1);
      end
    end
  end

  assign rd_data = rd_byp_r ? byp_data_r : (rd_ok_r ? rd_data_r : '0);

endmodule

`default_nettype wire

@@ hw/rtl/gb5_kernel.sv @@
// 5x5 window, class sums, coefficient products, final sum, saturation and output register.
`timescale 1ns / 1ps
`default_nettype none

module gb5_kernel (
  input  wire logic                       clk,
  input  wire gb5_pkg::stage_ld_t         ld,
  input  wire logic [gb5_pkg::PIX_W-1:0]  pix,
  input  wire gb5_pkg::ls_word_t          ls,
  input  wire logic                       border,
  input  wire logic                       last,
  input  wire gb5_pkg::coef_set_t         coef,
  output gb5_pkg::out_item_t              out_data
);
  import gb5_pkg::*;

  logic [PIX_W-1:0]   window_r [WIN_TAPS];
  logic [PIX_W-1:0]   col_new  [WIN_DIM];
  logic               border2_r, last2_r;

  logic [SUM_W-1:0]   sums_c [NUM_COEF];
  logic [SUM_W-1:0]   sum3_r [NUM_COEF];
  logic [PIX_W-1:0]   centre3_r;
  logic               border3_r, last3_r;

  logic [PROD_W-1:0]  prod4_r [NUM_COEF];
  logic [BPROD_W-1:0] bprod4_r;
  logic               border4_r, last4_r;

  logic [PAIR_W-1:0]  pair5_r [NUM_COEF/2];
  logic [PIX_W-1:0]   bpix5_r;
  logic               border5_r, last5_r;

  logic [ACC_W-1:0]   total_c;
  logic [PIX_W-1:0]   sat_c;
  out_item_t          out_data_r;

  always_comb begin
    for (int r = 0; r < LS_ROWS; r++) begin
      col_new[r] = ls[r];
    end
    col_new[WIN_DIM-1] = pix;
  end

  // Stage 2: shift the window left, new column enters at the right.
  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      for (int r = 0; r < WIN_DIM; r++) begin
        for (int c = 0; c < WIN_DIM - 1; c++) begin
          window_r[r*WIN_DIM + c] <= window_r[r*WIN_DIM + c + 1];
        end
        window_r[r*WIN_DIM + WIN_DIM - 1] <= col_new[r];
      end
      border2_r <= border;
      last2_r   <= last;
    end
  end

  // Stage 3: add up the taps that share a weight.
  always_comb begin
    for (int k = 0; k < NUM_COEF; k++) begin
      sums_c[k] = '0;
    end
    for (int i = 0; i < WIN_TAPS; i++) begin
      sums_c[TAP_CLASS[i]] = sums_c[TAP_CLASS[i]] + SUM_W'(window_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld3) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        sum3_r[k] <= sums_c[k];
      end
      centre3_r <= window_r[CENTER_TAP];
      border3_r <= border2_r;
      last3_r   <= last2_r;
    end
  end

  // Stage 4: one product per weight class, plus the border scale.
  always_ff @(posedge clk) begin
    if (ld.ld4) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        prod4_r[k] <= PROD_W'(sum3_r[k]) * PROD_W'(coef[k]);
      end
      bprod4_r  <= BPROD_W'(centre3_r) * BPROD_W'(BORDER_MUL);
      border4_r <= border3_r;
      last4_r   <= last3_r;
    end
  end

  // Stage 5: pairwise sums.
  always_ff @(posedge clk) begin
    if (ld.ld5) begin
      for (int k = 0; k < NUM_COEF/2; k++) begin
        pair5_r[k] <= PAIR_W'(prod4_r[2*k]) + PAIR_W'(prod4_r[2*k + 1]);
      end
      bpix5_r   <= bprod4_r[BPROD_W-1:BMUL_W];
      border5_r <= border4_r;
      last5_r   <= last4_r;
    end
  end

  always_comb begin
    total_c = ACC_W'(pair5_r[0]) + ACC_W'(pair5_r[1]) + ACC_W'(pair5_r[2]);
    if (|total_c[ACC_W-1:FRAC_W+PIX_W]) begin
      sat_c = '1;
    end else begin
      sat_c = total_c[FRAC_W+PIX_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_out) begin
      out_data_r.pixel_out <= border5_r ? bpix5_r : sat_c;
      out_data_r.frame_end <= last5_r;
    end
  end

  assign out_data = out_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/gb5_checker.sv @@
// Port-level checker for the blur stream core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module gb5_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire gb5_pkg::out_item_t out_data
);
  import gb5_pkg::*;

  logic       in_fire, out_fire;
  logic [7:0] pend_r;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Requests taken minus results given; sticks once saturated.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (pend_r != 8'hFF) begin
      if (in_fire && !out_fire) begin
        pend_r <= pend_r + 8'd1;
      end else if (!in_fire && out_fire && (pend_r != 8'd0)) begin
        pend_r <= pend_r - 8'd1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> (pend_r != 8'd0))
    else $error("result delivered without an earlier request");

endmodule

bind gaussian_blur_5x5_stream_core gb5_checker u_gb5_checker (.*);

`default_nettype wire

@@ test/gb5_blur_checker.sv @@
// Watches the blur core's ports, predicts every output pixel and compares it with the result.
`timescale 1ns / 1ps

module gb5_blur_checker #(
  parameter int MAX_WIDTH = gb5_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  gb5_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  gb5_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [gb5_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gb5_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           end_of_run,
  output int unsigned                    pending,
  output int unsigned                    error_count
);

  import gb5_pkg::*;

  localparam int PRINT_LIMIT = 40;

  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [COEF_W-1:0]   weights [NUM_COEF];

  ls_word_t            col_history [MAX_WIDTH];
  logic [PIX_W-1:0]    nbhd [WIN_TAPS];
  int unsigned         in_col, in_row, out_col, out_row;

  out_item_t           expected_pixels [$];
  bit                  leftovers_done;

  initial begin
    error_count = 0;
    pending = 0;
    leftovers_done = 1'b0;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("%0t ns mismatch: %s", $time, what);
  endtask

  // Weight class by squared distance from the center tap.
  function automatic int weight_sel(input int dy, input int dx);
    case (dy * dy + dx * dx)
      0: return 0;
      1: return 1;
      2: return 2;
      4: return 3;
      5: return 4;
      default: return 5;
    endcase
  endfunction

  task automatic absorb_item(input in_item_t item);
    int unsigned w, h, col, oc, orow, centre, bprod;
    int r, c;
    logic [PIX_W-1:0] fresh;
    ls_word_t hist;
    bit primed, last;
    logic [63:0] acc;
    out_item_t res;

    w = width_reg < MIN_SIZE ? MIN_SIZE : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    h = height_reg < MIN_SIZE ? MIN_SIZE : height_reg;
    fresh = item.cmd ? '0 : item.pixel_in;
    col = in_col < w ? in_col : 0;
    hist = col_history[col];
    primed = (in_row >= 3) || (in_row == 2 && col >= 2);

    // Shift the neighborhood left; the new column comes from the line history.
    for (r = 0; r < WIN_DIM; r++)
      for (c = 0; c < WIN_DIM - 1; c++)
        nbhd[r * WIN_DIM + c] = nbhd[r * WIN_DIM + c + 1];
    for (r = 0; r < LS_ROWS; r++)
      nbhd[r * WIN_DIM + WIN_DIM - 1] = hist[r];
    nbhd[WIN_TAPS - 1] = fresh;
    col_history[col] = {fresh, hist[3], hist[2], hist[1]};

    if (col + 1 >= w) begin
      in_col = 0;
      if (in_row < 3) in_row++;
    end else begin
      in_col = col + 1;
    end

    if (primed) begin
      oc = out_col < w ? out_col : 0;
      orow = out_row < h ? out_row : 0;
      centre = nbhd[CENTER_TAP];
      if (oc <= 2 || orow <= 2 || oc >= w - 2 || orow >= h - 2) begin
        bprod = centre * BORDER_MUL;
        res.pixel_out = 8'(bprod >> FRAC_W);
      end else begin
        acc = '0;
        for (r = 0; r < WIN_DIM; r++)
          for (c = 0; c < WIN_DIM; c++)
            acc += 64'(weights[weight_sel(r - 2, c - 2)]) * 64'(nbhd[r * WIN_DIM + c]);
        acc = acc >> FRAC_W;
        res.pixel_out = acc > 64'd255 ? 8'hFF : acc[PIX_W-1:0];
      end

      last = (oc + 1 >= w) && (orow + 1 >= h);
      if (last) begin
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
      end else if (oc + 1 >= w) begin
        out_col = 0;
        out_row = orow + 1;
      end else begin
        out_col = oc + 1;
        out_row = orow;
      end
      res.frame_end = last;
      expected_pixels.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    out_item_t oldest;
    if (!rst_n) begin
      width_reg = 11'd1024;
      height_reg = 12'd1024;
      foreach (weights[k]) weights[k] = '0;
      foreach (col_history[k]) col_history[k] = '0;
      foreach (nbhd[k]) nbhd[k] = '0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      expected_pixels.delete();
    end else begin
      // Retire results before absorbing this edge's input request.
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result with nothing predicted: pixel_out %0d frame_end %0b",
                                    out_data.pixel_out, out_data.frame_end));
        end else begin
          oldest = expected_pixels.pop_front();
          if (out_data.pixel_out !== oldest.pixel_out)
            report_mismatch($sformatf("pixel_out %0d, predicted %0d",
                                      out_data.pixel_out, oldest.pixel_out));
          if (out_data.frame_end !== oldest.frame_end)
            report_mismatch($sformatf("frame_end %0b, predicted %0b",
                                      out_data.frame_end, oldest.frame_end));
        end
      end
      if (in_valid && in_ready) absorb_item(in_data);
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_reg = cfg_data[WIDTH_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_data[HEIGHT_W-1:0];
          default:          weights[int'(cfg_index) - int'(CFG_COEF_D0)] = cfg_data;
        endcase
      end
      if (end_of_run && !leftovers_done) begin
        leftovers_done = 1'b1;
        while (expected_pixels.size() != 0) begin
          oldest = expected_pixels.pop_front();
          report_mismatch($sformatf("predicted pixel %0d never came out", oldest.pixel_out));
        end
      end
    end
    pending <= expected_pixels.size();
  end

endmodule

@@ test/tb_gaussian_blur_5x5_stream_core.sv @@
// Top of the blur core testbench: clock, reset, configuration and pixel stimulus, verdict.
`timescale 1ns / 1ps

module tb_gaussian_blur_5x5_stream_core;

  import gb5_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS  = 700;
  localparam int QUIET_TAIL    = 300;
  localparam int NUM_REGS      = int'(CFG_COEF_D8) + 1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  end_of_run = 1'b0;

  int unsigned           pending;
  int unsigned           error_count;
  bit                    quiet = 1'b0;
  int unsigned           sink_hold = 0;
  int unsigned           idle_cycles = 0;
  int unsigned           sent_items = 0;
  logic [CFG_DATA_W-1:0] reg_plan [NUM_REGS];

  gaussian_blur_5x5_stream_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gb5_blur_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .end_of_run  (end_of_run),
    .pending     (pending),
    .error_count (error_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result side in bursts of random length; no new burst starts once quiet is set.
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      sink_hold <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(input logic cmd, input logic [PIX_W-1:0] pix);
    in_item_t item;
    int unsigned gap;
    item.cmd = cmd;
    item.pixel_in = pix;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  // Frame body: pixels with a rare flush. Drain: flushes with some stray pixels.
  task automatic send_scene_item(input bit drain);
    if (!drain) begin
      if ($urandom_range(0, 39) == 0) send_item(1'b1, pick_pixel());
      else send_item(1'b0, pick_pixel());
    end else begin
      if ($urandom_range(0, 3) == 0) send_item(1'b0, pick_pixel());
      else send_item(1'b1, pick_pixel());
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_registers();
    int i;
    for (i = int'(CFG_IMAGE_WIDTH); i <= int'(CFG_COEF_D8); i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= reg_plan[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic plan_weights();
    int k;
    int unsigned mode;
    mode = $urandom_range(0, 7);
    for (k = 0; k < NUM_COEF; k++) begin
      case (mode)
        0:       reg_plan[int'(CFG_COEF_D0) + k] = '0;
        1:       reg_plan[int'(CFG_COEF_D0) + k] = '1;
        2, 3:    reg_plan[int'(CFG_COEF_D0) + k] = CFG_DATA_W'($urandom);
        default: reg_plan[int'(CFG_COEF_D0) + k] =
                   CFG_DATA_W'($urandom_range(0, 3000 << $urandom_range(0, 3)));
      endcase
    end
  endtask

  task automatic stream_frame(input int unsigned w, input int unsigned h);
    int unsigned k, pause_at;
    pause_at = $urandom_range(0, w * h + 2 * w + 1);
    for (k = 0; k < w * h + 2 * w + 2; k++) begin
      if (k == pause_at && $urandom_range(0, 3) == 0) wait_drained();
      send_scene_item(k >= w * h);
    end
  endtask

  task automatic stream_span(input int unsigned n);
    repeat (n) send_scene_item(1'b0);
  endtask

  task automatic random_phase();
    int unsigned w_reg, h_reg, w_eff, h_eff, pick;
    w_reg = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12);
    pick = $urandom_range(0, 19);
    case (pick)
      0:       h_reg = $urandom_range(0, 4);
      1:       h_reg = 4095;
      2:       h_reg = $urandom_range(0, 4095);
      default: h_reg = $urandom_range(5, 9);
    endcase
    w_eff = w_reg < MIN_SIZE ? MIN_SIZE : w_reg;
    h_eff = h_reg < MIN_SIZE ? MIN_SIZE : h_reg;
    reg_plan[CFG_IMAGE_WIDTH] = CFG_DATA_W'(w_reg);
    reg_plan[CFG_IMAGE_HEIGHT] = CFG_DATA_W'(h_reg);
    plan_weights();
    wait_drained();
    load_registers();

    pick = $urandom_range(0, 9);
    if (h_eff > 12) begin
      // Tall frame: stream a few rows only, the next setting lands mid-frame.
      stream_span(w_eff * $urandom_range(3, 8));
    end else if (pick == 0) begin
      repeat ($urandom_range(5, 40)) send_item(1'($urandom_range(0, 1)), pick_pixel());
    end else if (pick == 1) begin
      stream_span($urandom_range(1, w_eff * h_eff));
    end else begin
      repeat ($urandom_range(1, 3)) stream_frame(w_eff, h_eff);
    end
  endtask

  initial begin
    int unsigned k, random_goal;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest frame through out-of-range sizes; every output is a border pixel.
    reg_plan[CFG_IMAGE_WIDTH] = CFG_DATA_W'(3);
    reg_plan[CFG_IMAGE_HEIGHT] = '0;
    for (k = 0; k < NUM_COEF; k++) reg_plan[int'(CFG_COEF_D0) + k] = '1;
    load_registers();
    for (k = 0; k < MIN_SIZE * MIN_SIZE; k++) begin
      if (k == 7) send_item(1'b1, 8'hFF);
      else send_item(1'b0, (k % 2) ? 8'hFF : 8'h00);
    end
    for (k = 0; k < 2 * MIN_SIZE + 2; k++) begin
      if (k == 3) send_item(1'b0, 8'hAA);
      else send_item(1'b1, 8'h55);
    end

    // Widest line, clamped or exact; fill a little more than one full line.
    wait_drained();
    reg_plan[CFG_IMAGE_WIDTH] = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'(2047)
                                                            : CFG_DATA_W'(MAX_WIDTH_DEF);
    reg_plan[CFG_IMAGE_HEIGHT] = CFG_DATA_W'(MIN_SIZE);
    plan_weights();
    load_registers();
    stream_span(MAX_WIDTH_DEF + 40);

    random_goal = sent_items + RANDOM_ITEMS;
    while (sent_items < random_goal) begin
      if (sent_items + QUIET_TAIL >= random_goal) quiet = 1'b1;
      random_phase();
    end

    wait_drained();
    end_of_run <= 1'b1;
    repeat (2) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/gb5_pkg.sv
hw/rtl/gb5_pos_ctrl.sv
hw/rtl/gb5_line_buf.sv
hw/rtl/gb5_kernel.sv
hw/rtl/gaussian_blur_5x5_stream_core.sv
hw/rtl/gb5_checker.sv
test/gb5_blur_checker.sv
test/tb_gaussian_blur_5x5_stream_core.sv
